[sv/bcc_pkg.sv]
`timescale 1ns / 1ps

package bcc_pkg;

    // Field and state widths
    localparam int CodeW    = 8;
    localparam int SetpW    = 8;
    localparam int PwmW     = 8;
    localparam int VoltW    = 10;
    localparam int CurW     = 14;
    localparam int SetSumW  = 12;
    localparam int OffSumW  = 22;
    localparam int FracW    = 16;
    localparam int UsedW    = 16;
    localparam int PowW     = 17;
    localparam int RegW     = 16;
    localparam int ByteRegW = 8;
    localparam int CfgAddrW = 2;
    localparam int DecW     = 10;

    // Shared divider: dividend / quotient shift register and remainder
    localparam int DivW     = 24;
    localparam int DivRemW  = 16;
    localparam int DivCntW  = 5;

    // Power scaling: x / 100 == (x * ceil(2^31 / 100)) >> 31 for every x below 2^24
    localparam int RecipW     = 25;
    localparam int ScaleShift = 31;

    // Packed stream widths
    localparam int InTdataW  = 40;
    localparam int OutTdataW = 56;

    // Register indexes
    localparam logic [CfgAddrW-1:0] CFG_BOARD_OFFSET     = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_PER_MOTOR_OFFSET = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_UNITS_PER_MAH    = 2'd2;

    // Register reset values
    localparam logic [ByteRegW-1:0] BOARD_OFFSET_RST     = 8'd5;
    localparam logic [ByteRegW-1:0] PER_MOTOR_OFFSET_RST = 8'd2;
    localparam logic [RegW-1:0]     UNITS_PER_MAH_RST    = 16'd720;

    // Codes and limits
    localparam logic [CodeW-1:0] CODE_INVALID  = 8'd255;
    localparam logic [CodeW-1:0] CODE_EXT_BASE = 8'd200;
    localparam logic [PwmW-1:0]  PWM_NONE      = 8'd255;
    localparam logic [PwmW-1:0]  PWM_REDUNDANT = 8'd254;
    localparam logic [CurW-1:0]  CUR_FULL_RES  = 14'd255;
    localparam logic [RegW-1:0]  POWER_DIVISOR = 16'd100;
    localparam logic [RecipW-1:0] POWER_RECIP  = 25'd21474837;
    localparam logic [RegW-1:0]  UNITS_MIN     = 16'd64;
    localparam logic [PowW-1:0]  POWER_MAX     = 17'd131071;
    localparam logic [DivCntW-1:0] DIV_LAST_STEP = 5'd23;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORRECT,
        ST_MUL,
        ST_SCALE,
        ST_DIV_MAH,
        ST_FINISH
    } state_t;

    // Decode a current code into 0.1 A units
    function automatic logic [DecW-1:0] decode_current(
        input logic [CodeW-1:0] code,
        input logic             high
    );
        logic [DecW-1:0] ext;
        logic [DecW-1:0] res;
        ext = DecW'(code - CODE_EXT_BASE);
        if (code == CODE_INVALID)
            res = '0;
        else if (code <= CODE_EXT_BASE || !high)
            res = DecW'(code);
        else
            res = DecW'(CODE_EXT_BASE) + (ext << 3) + (ext << 1);
        return res;
    endfunction

endpackage

[sv/battery_charge_counter.sv]
`timescale 1ns / 1ps

// Channel   Dir  Signals                      Contents
// s_axis    in   tvalid tready tdata tuser    one motor report, tlast ends interval
//                tlast
// m_axis    out  tvalid tready tdata          one result per interval
// cfg       in   cfg_we cfg_addr cfg_wdata    register writes, no read-back
//
// A report without tlast is taken and the block stays ready.
// A report with tlast makes the block busy before the next request is taken: its own
// accept, a correction step, a multiply step, a step that scales
// the product by a reciprocal of 100 and loads the divider, the steps of the shared
// one-bit-per-cycle divider for the mAh step count, and a step that loads the result
// register. That final step waits while the result register still holds an
// untaken result.
// Reset is asynchronous, active low; control, state and configuration registers return to their reset values.
module battery_charge_counter #(
    parameter int MOTORS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // present[0], current_code[8:1], setpoint[16:9], max_pwm[24:17],
    // battery_voltage[34:25], zero fill[39:35]
    input  logic [bcc_pkg::InTdataW-1:0]  s_axis_tdata,
    // high_range[0]
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // total_current[13:0], power_watts[30:14], used_mah[46:31],
    // min_max_pwm[54:47], redundancy_active[55]
    output logic [bcc_pkg::OutTdataW-1:0] m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [bcc_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [bcc_pkg::RegW-1:0]      cfg_wdata
);
    import bcc_pkg::*;

    localparam int CntW    = $clog2(MOTORS + 1);
    localparam int MotW    = CntW + ByteRegW;
    localparam int RunW    = CurW + 1;
    localparam int SumW    = FracW + 1;
    localparam int ScaledW = DivW + RecipW;

    // Input fields
    logic             in_present;
    logic [CodeW-1:0] in_code;
    logic [SetpW-1:0] in_setpoint;
    logic [PwmW-1:0]  in_pwm;
    logic [VoltW-1:0] in_volts;

    // Control state
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // Configuration registers
    logic [ByteRegW-1:0] board_offset_reg;
    logic [ByteRegW-1:0] per_motor_offset_reg;
    logic [RegW-1:0]     units_per_mah_reg;

    // Interval and long-term state
    logic [CurW-1:0]    current_sum_reg, current_sum_next;
    logic [SetSumW-1:0] setpoint_sum_reg, setpoint_sum_next;
    logic [CntW-1:0]    motor_count_reg, motor_count_next;
    logic [PwmW-1:0]    running_min_reg, running_min_next;
    logic               redundancy_reg, redundancy_next;
    logic [OffSumW-1:0] offset_sum_reg, offset_sum_next;
    logic [CurW-1:0]    current_offset_reg, current_offset_next;
    logic [FracW-1:0]   fraction_reg, fraction_next;
    logic [UsedW-1:0]   used_charge_reg, used_charge_next;

    // Working registers
    logic [VoltW-1:0]   volts_reg, volts_next;
    logic [CurW-1:0]    cur_reg, cur_next;
    logic [PowW-1:0]    power_reg, power_next;
    logic [DivW-1:0]    quo_reg, quo_next;
    logic [DivRemW-1:0] rem_reg, rem_next;
    logic [RegW-1:0]    divisor_reg, divisor_next;
    logic [DivCntW-1:0] step_reg, step_next;

    // Result register
    logic [CurW-1:0]  out_cur_reg, out_cur_next;
    logic [PowW-1:0]  out_power_reg, out_power_next;
    logic [UsedW-1:0] out_used_reg, out_used_next;
    logic [PwmW-1:0]  out_min_reg, out_min_next;
    logic             out_red_reg, out_red_next;

    // Datapath helpers
    logic [DivRemW:0]   div_trial;
    logic               div_ge;
    logic [DivRemW:0]   div_diff;
    logic [DivRemW-1:0] step_rem;
    logic [DivW-1:0]    step_quo;
    logic [ScaledW-1:0] scaled;
    logic [PowW-1:0]    power_sat;
    logic [CurW-1:0]    mul_cur;
    logic [DivW-1:0]    product;
    logic [CurW-1:0]    run_sub;
    logic [MotW-1:0]    motor_term;
    logic [RunW-1:0]    run_total;
    logic [CurW-1:0]    idle_offset;
    logic [SumW-1:0]    mah_sum;
    logic [DivW-1:0]    mah_dividend;
    logic [RegW-1:0]    units_eff;
    logic [UsedW-1:0]   used_sum;

    // Unpack the request
    assign in_present  = s_axis_tdata[0];
    assign in_code     = s_axis_tdata[8:1];
    assign in_setpoint = s_axis_tdata[16:9];
    assign in_pwm      = s_axis_tdata[24:17];
    assign in_volts    = s_axis_tdata[34:25];

    assign out_free = !out_valid_reg || m_axis_tready;

    // Shared divider step: shift one dividend bit into the remainder
    assign div_trial = {rem_reg, quo_reg[DivW-1]};
    assign div_ge    = div_trial >= {1'b0, divisor_reg};
    assign div_diff  = div_trial - {1'b0, divisor_reg};
    assign step_rem  = div_ge ? div_diff[DivRemW-1:0] : div_trial[DivRemW-1:0];
    assign step_quo  = {quo_reg[DivW-2:0], div_ge};

    // Power: product over 100 by reciprocal multiply, then saturate
    assign scaled    = ScaledW'(quo_reg) * ScaledW'(POWER_RECIP);
    assign power_sat = (scaled[ScaledW-1:ScaleShift+PowW] != '0)
                       ? POWER_MAX : scaled[ScaleShift+PowW-1:ScaleShift];

    // Power product: coarse current drops two bits, divisor 25 becomes 100
    assign mul_cur = (cur_reg < CUR_FULL_RES) ? cur_reg : {cur_reg[CurW-1:2], 2'b00};
    assign product = {{(DivW-VoltW){1'b0}}, volts_reg} * {{(DivW-CurW){1'b0}}, mul_cur};

    // Running correction terms
    assign run_sub     = (current_sum_reg > current_offset_reg)
                         ? current_sum_reg - current_offset_reg : '0;
    assign motor_term  = MotW'(motor_count_reg) * MotW'(per_motor_offset_reg);
    assign run_total   = RunW'(run_sub) + RunW'(board_offset_reg) + RunW'(motor_term);
    assign idle_offset = offset_sum_reg[OffSumW-1:8];

    // Charge count operands
    assign mah_sum      = SumW'(fraction_reg) + SumW'(cur_reg);
    assign mah_dividend = (mah_sum == '0) ? '0 : DivW'(mah_sum - SumW'(1));
    assign units_eff    = (units_per_mah_reg < UNITS_MIN) ? UNITS_MIN : units_per_mah_reg;
    assign used_sum     = used_charge_reg + quo_reg[UsedW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tlast)
                    state_next = ST_CORRECT;
            end
            ST_CORRECT: state_next = ST_MUL;
            ST_MUL:     state_next = ST_SCALE;
            ST_SCALE:   state_next = ST_DIV_MAH;
            ST_DIV_MAH:
            begin
                if (step_reg == DIV_LAST_STEP)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        current_sum_next    = current_sum_reg;
        setpoint_sum_next   = setpoint_sum_reg;
        motor_count_next    = motor_count_reg;
        running_min_next    = running_min_reg;
        redundancy_next     = redundancy_reg;
        offset_sum_next     = offset_sum_reg;
        current_offset_next = current_offset_reg;
        fraction_next       = fraction_reg;
        used_charge_next    = used_charge_reg;
        volts_next          = volts_reg;
        cur_next            = cur_reg;
        power_next          = power_reg;
        quo_next            = quo_reg;
        rem_next            = rem_reg;
        divisor_next        = divisor_reg;
        step_next           = step_reg;
        out_cur_next        = out_cur_reg;
        out_power_next      = out_power_reg;
        out_used_next       = out_used_reg;
        out_min_next        = out_min_reg;
        out_red_next        = out_red_reg;
        out_valid_next      = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the voltage; add a present motor, up to MOTORS, to the interval sums
                if (s_axis_tvalid)
                begin
                    volts_next = in_volts;
                    if (in_present && motor_count_reg < CntW'(MOTORS))
                    begin
                        motor_count_next  = motor_count_reg + CntW'(1);
                        current_sum_next  = current_sum_reg
                                            + CurW'(decode_current(in_code, s_axis_tuser));
                        setpoint_sum_next = setpoint_sum_reg + SetSumW'(in_setpoint);
                        if (in_pwm <= running_min_reg)
                            running_min_next = in_pwm;
                        else if (in_pwm == PWM_NONE)
                            redundancy_next = 1'b0;
                    end
                end
            end
            ST_CORRECT:
            begin
                // Idle: track offset by leaky sum; running: apply offsets
                if (setpoint_sum_reg == '0)
                begin
                    current_offset_next = idle_offset;
                    offset_sum_next     = offset_sum_reg - OffSumW'(idle_offset)
                                          + OffSumW'(current_sum_reg);
                    cur_next            = CurW'(board_offset_reg);
                    redundancy_next     = 1'b0;
                end
                else
                begin
                    cur_next = run_total[CurW-1:0];
                end
            end
            ST_MUL:
            begin
                // Hold V*I for scaling
                quo_next = product;
            end
            ST_SCALE:
            begin
                // Hold the power, then load the divider for the mAh steps
                power_next   = power_sat;
                quo_next     = mah_dividend;
                rem_next     = '0;
                divisor_next = units_eff;
                step_next    = '0;
            end
            ST_DIV_MAH:
            begin
                quo_next  = step_quo;
                rem_next  = step_rem;
                step_next = step_reg + DivCntW'(1);
            end
            ST_FINISH:
            begin
                // Load the result and start the next interval
                if (out_free)
                begin
                    fraction_next     = (mah_sum == '0) ? '0 : rem_reg + DivRemW'(1);
                    used_charge_next  = used_sum;
                    out_cur_next      = cur_reg;
                    out_power_next    = power_reg;
                    out_used_next     = used_sum;
                    out_min_next      = running_min_reg;
                    out_red_next      = redundancy_reg;
                    out_valid_next    = 1'b1;
                    current_sum_next  = '0;
                    setpoint_sum_next = '0;
                    motor_count_next  = '0;
                    running_min_next  = PWM_NONE;
                    if (running_min_reg == PWM_REDUNDANT)
                        redundancy_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {out_red_reg, out_min_reg, out_used_reg, out_power_reg, out_cur_reg};
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_offset_reg     <= BOARD_OFFSET_RST;
            per_motor_offset_reg <= PER_MOTOR_OFFSET_RST;
            units_per_mah_reg    <= UNITS_PER_MAH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BOARD_OFFSET:     board_offset_reg     <= cfg_wdata[ByteRegW-1:0];
                CFG_PER_MOTOR_OFFSET: per_motor_offset_reg <= cfg_wdata[ByteRegW-1:0];
                CFG_UNITS_PER_MAH:    units_per_mah_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            out_valid_reg      <= 1'b0;
            step_reg           <= '0;
            current_sum_reg    <= '0;
            setpoint_sum_reg   <= '0;
            motor_count_reg    <= '0;
            running_min_reg    <= PWM_NONE;
            redundancy_reg     <= 1'b0;
            offset_sum_reg     <= '0;
            current_offset_reg <= '0;
            fraction_reg       <= '0;
            used_charge_reg    <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
            step_reg           <= step_next;
            current_sum_reg    <= current_sum_next;
            setpoint_sum_reg   <= setpoint_sum_next;
            motor_count_reg    <= motor_count_next;
            running_min_reg    <= running_min_next;
            redundancy_reg     <= redundancy_next;
            offset_sum_reg     <= offset_sum_next;
            current_offset_reg <= current_offset_next;
            fraction_reg       <= fraction_next;
            used_charge_reg    <= used_charge_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        volts_reg     <= volts_next;
        cur_reg       <= cur_next;
        power_reg     <= power_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        out_cur_reg   <= out_cur_next;
        out_power_reg <= out_power_next;
        out_used_reg  <= out_used_next;
        out_min_reg   <= out_min_next;
        out_red_reg   <= out_red_next;
    end

endmodule

[sv/bcc_checker.sv]
`timescale 1ns / 1ps

module bcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bcc_pkg::OutTdataW-1:0] m_axis_tdata
);

    // Stalled result holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Closing report makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("request taken while interval closes");

    // Ordinary report keeps the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> s_axis_tready)
        else $error("ordinary report stalled input");

    // New result appears only at the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without closing report");

endmodule

bind battery_charge_counter bcc_checker u_bcc_checker (.*);
